// ===== rtl/trg_pkg.sv =====
package trg_pkg;

  localparam int DIV_W     = 19;
  localparam int DVS_W     = 14;
  localparam int STEP_W    = 5;
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_W - 1);

  localparam logic [10:0] CNT_MAX = 11'd2047;

  localparam logic [20:0] CP_UPPER_A = 21'h41;
  localparam logic [20:0] CP_UPPER_Z = 21'h5A;
  localparam logic [20:0] CP_LOWER_A = 21'h61;
  localparam logic [20:0] CP_LOWER_Z = 21'h7A;
  localparam logic [20:0] CP_CYR_LO  = 21'h410;
  localparam logic [20:0] CP_CYR_HI  = 21'h44F;
  localparam logic [20:0] CP_CYR_IO  = 21'h401;
  localparam logic [20:0] CP_CYR_YO  = 21'h451;
  localparam logic [20:0] CP_TAB     = 21'd9;
  localparam logic [20:0] CP_CR      = 21'd13;
  localparam logic [20:0] CP_SPACE   = 21'd32;
  localparam logic [20:0] CP_PERIOD  = 21'h2E;
  localparam logic [20:0] CP_BANG    = 21'h21;
  localparam logic [20:0] CP_QUERY   = 21'h3F;
  localparam logic [20:0] CP_ELLIPS  = 21'h2026;

  localparam logic [9:0]  COEF_L     = 10'd588;
  localparam logic [11:0] COEF_S     = 12'd2960;
  localparam logic signed [31:0] COEF_C = 32'sd158000;
  localparam logic signed [31:0] HALF_UNIT = 32'sd5000;
  localparam logic signed [31:0] RND_LIMIT = 32'sd320000;
  localparam logic [6:0]  PCT        = 7'd100;

  // ceil(2^31 / 10000): exact floor division for every index below RND_LIMIT
  localparam logic [17:0] RECIP_UNIT  = 18'd214749;
  localparam int          RECIP_SHIFT = 31;

  localparam logic [11:0] RST_MIN_LEN = 12'd50;
  localparam logic [4:0]  RST_TOP     = 5'd16;

  localparam logic REG_MIN_LEN = 1'b0;
  localparam logic REG_TOP     = 1'b1;

  typedef enum logic [1:0] {
    CLS_PRESCHOOL = 2'd0,
    CLS_GRADE     = 2'd1,
    CLS_ABOVE     = 2'd2,
    CLS_NO_WORDS  = 2'd3
  } grade_class_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LOAD = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_RND  = 7'b0010000,
    ST_SCL  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic take;
    logic load_div;
    logic step_div;
    logic load_mul;
    logic load_rnd;
    logic load_scl;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic skip;
  } sts_t;

endpackage

// ===== rtl/trg_in_if.sv =====
interface trg_in_if;
  logic        valid;
  logic        ready;
  logic [20:0] char_code;
  logic        last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== rtl/trg_out_if.sv =====
interface trg_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] char_count;
  logic [10:0] letter_count;
  logic [10:0] word_count;
  logic [10:0] sentence_count;
  logic        missing_end_mark;
  logic [1:0]  grade_class;
  logic [4:0]  grade;

  modport source (output valid, output char_count, output letter_count, output word_count,
                  output sentence_count, output missing_end_mark, output grade_class,
                  output grade, input ready);
  modport sink   (input valid, input char_count, input letter_count, input word_count,
                  input sentence_count, input missing_end_mark, input grade_class,
                  input grade, output ready);
endinterface

// ===== rtl/trg_ctrl.sv =====
module trg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  trg_pkg::sts_t sts,
  output trg_pkg::cmd_t cmd
);

  trg_pkg::state_t state, state_next;
  logic [trg_pkg::STEP_W-1:0] step, step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      trg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && in_last) state_next = trg_pkg::ST_LOAD;
      end
      trg_pkg::ST_LOAD: begin
        cmd.load_div = 1'b1;
        step_next    = '0;
        state_next   = sts.skip ? trg_pkg::ST_FIN : trg_pkg::ST_DIV;
      end
      trg_pkg::ST_DIV: begin
        cmd.step_div = 1'b1;
        step_next    = step + 1'b1;
        if (step == trg_pkg::DIV_LAST) begin
          state_next = trg_pkg::ST_MUL;
        end
      end
      trg_pkg::ST_MUL: begin
        cmd.load_mul = 1'b1;
        state_next   = trg_pkg::ST_RND;
      end
      trg_pkg::ST_RND: begin
        cmd.load_rnd = 1'b1;
        state_next   = trg_pkg::ST_SCL;
      end
      trg_pkg::ST_SCL: begin
        // scale the rounded index down by the unit
        cmd.load_scl = 1'b1;
        state_next   = trg_pkg::ST_FIN;
      end
      trg_pkg::ST_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = trg_pkg::ST_IDLE;
        end
      end
      default: state_next = trg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= trg_pkg::ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> (state == trg_pkg::ST_LOAD))
    else $error("final item did not start grading");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == trg_pkg::ST_DIV) |-> (step <= trg_pkg::DIV_LAST))
    else $error("divide step counter overran");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == trg_pkg::ST_FIN))
    else $error("result raised outside finish state");

endmodule

// ===== rtl/trg_dpath.sv =====
module trg_dpath #(
  parameter int MAX_TEXT = 2048
) (
  input  logic          clk,
  input  logic          rst,
  input  trg_pkg::cmd_t cmd,
  output trg_pkg::sts_t sts,
  input  logic [20:0]   char_code,
  input  logic          last_char,
  input  logic [11:0]   min_len,
  input  logic [4:0]    top_grade,
  output logic [10:0]   char_count,
  output logic [10:0]   letter_count,
  output logic [10:0]   word_count,
  output logic [10:0]   sentence_count,
  output logic          missing_end_mark,
  output logic [1:0]    grade_class,
  output logic [4:0]    grade
);

  localparam int CAP_INT = (MAX_TEXT < 4095) ? MAX_TEXT : 4095;
  localparam logic [11:0] TOTAL_CAP = 12'(CAP_INT);

  function automatic logic is_letter(input logic [20:0] c);
    is_letter = (c >= trg_pkg::CP_UPPER_A && c <= trg_pkg::CP_UPPER_Z) ||
                (c >= trg_pkg::CP_LOWER_A && c <= trg_pkg::CP_LOWER_Z) ||
                (c >= trg_pkg::CP_CYR_LO && c <= trg_pkg::CP_CYR_HI) ||
                c == trg_pkg::CP_CYR_IO || c == trg_pkg::CP_CYR_YO;
  endfunction

  function automatic logic is_space(input logic [20:0] c);
    is_space = (c >= trg_pkg::CP_TAB && c <= trg_pkg::CP_CR) || c == trg_pkg::CP_SPACE;
  endfunction

  function automatic logic is_mark(input logic [20:0] c);
    is_mark = c == trg_pkg::CP_PERIOD || c == trg_pkg::CP_BANG ||
              c == trg_pkg::CP_QUERY || c == trg_pkg::CP_ELLIPS;
  endfunction

  // running counts
  logic [11:0] total, total_next;
  logic [10:0] letters, letters_next;
  logic [10:0] words, words_next;
  logic [10:0] sents, sents_next;
  logic        in_word, in_word_next;
  logic        after, after_next;
  logic        letter;

  // per-text snapshot
  logic [10:0] s_chars, s_letters, s_words, s_sents;
  logic        s_missing, s_short, s_nowords;
  logic [10:0] chars_w, sents_eff;
  logic        missing_w;

  // divider lanes and grade arithmetic
  logic [trg_pkg::DIV_W-1:0] qa, qb;
  logic [trg_pkg::DVS_W-1:0] ra, rb, dvs;
  logic [trg_pkg::DVS_W:0]   sha, shb;
  logic [26:0] p_l;
  logic [29:0] p_s;
  logic signed [31:0] v, x;
  logic [trg_pkg::DIV_W+17:0] scl_p;
  logic        neg, big;
  logic [1:0]  cls_w;
  logic [4:0]  grade_w;

  always_comb begin
    letter       = is_letter(char_code);
    total_next   = (total < TOTAL_CAP) ? total + 1'b1 : TOTAL_CAP;
    letters_next = letters;
    words_next   = words;
    sents_next   = sents;
    after_next   = after;
    in_word_next = letter;
    if (letter) begin
      if (letters != trg_pkg::CNT_MAX) letters_next = letters + 1'b1;
      if (!in_word && words != trg_pkg::CNT_MAX) words_next = words + 1'b1;
    end
    if (is_mark(char_code) && !after) begin
      if (sents != trg_pkg::CNT_MAX) sents_next = sents + 1'b1;
      after_next = 1'b1;
    end else if (is_space(char_code)) begin
      after_next = 1'b0;
    end
    missing_w = (sents_next == 11'd0) && (letters_next != 11'd0);
    sents_eff = missing_w ? 11'd1 : sents_next;
    // drop the trailing newline from the character total
    if (total_next == 12'd0) chars_w = 11'd0;
    else if (total_next > 12'd2048) chars_w = trg_pkg::CNT_MAX;
    else chars_w = 11'(total_next - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total   <= '0;
      letters <= '0;
      words   <= '0;
      sents   <= '0;
      in_word <= 1'b0;
      after   <= 1'b0;
    end else if (cmd.take) begin
      if (last_char) begin
        total   <= '0;
        letters <= '0;
        words   <= '0;
        sents   <= '0;
        in_word <= 1'b0;
        after   <= 1'b0;
      end else begin
        total   <= total_next;
        letters <= letters_next;
        words   <= words_next;
        sents   <= sents_next;
        in_word <= in_word_next;
        after   <= after_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && last_char) begin
      s_chars   <= chars_w;
      s_letters <= letters_next;
      s_words   <= words_next;
      s_sents   <= sents_eff;
      s_missing <= missing_w;
      s_short   <= total_next < min_len;
      s_nowords <= words_next == 11'd0;
    end
  end

  assign sts.skip = s_short || s_nowords;

  assign sha = {ra, qa[trg_pkg::DIV_W-1]};
  assign shb = {rb, qb[trg_pkg::DIV_W-1]};

  assign scl_p = qa * trg_pkg::RECIP_UNIT;

  always_comb begin
    v = $signed({5'b0, p_l}) - $signed({2'b0, p_s}) - trg_pkg::COEF_C;
    x = v + trg_pkg::HALF_UNIT;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      qa  <= trg_pkg::DIV_W'(s_letters * trg_pkg::PCT);
      qb  <= trg_pkg::DIV_W'(s_sents * trg_pkg::PCT);
      ra  <= '0;
      rb  <= '0;
      dvs <= trg_pkg::DVS_W'(s_words);
    end else if (cmd.step_div) begin
      if (sha >= {1'b0, dvs}) begin
        ra <= trg_pkg::DVS_W'(sha - {1'b0, dvs});
        qa <= {qa[trg_pkg::DIV_W-2:0], 1'b1};
      end else begin
        ra <= sha[trg_pkg::DVS_W-1:0];
        qa <= {qa[trg_pkg::DIV_W-2:0], 1'b0};
      end
      if (shb >= {1'b0, dvs}) begin
        rb <= trg_pkg::DVS_W'(shb - {1'b0, dvs});
        qb <= {qb[trg_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rb <= shb[trg_pkg::DVS_W-1:0];
        qb <= {qb[trg_pkg::DIV_W-2:0], 1'b0};
      end
    end else if (cmd.load_rnd) begin
      // hold negative and out-of-range indexes as flags, scale the rest
      neg <= v[31];
      big <= !v[31] && (x >= trg_pkg::RND_LIMIT);
      qa  <= (!v[31] && x < trg_pkg::RND_LIMIT) ? x[trg_pkg::DIV_W-1:0] : '0;
      qb  <= '0;
      ra  <= '0;
      rb  <= '0;
    end else if (cmd.load_scl) begin
      qa <= trg_pkg::DIV_W'(scl_p[trg_pkg::RECIP_SHIFT+4:trg_pkg::RECIP_SHIFT]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mul) begin
      p_l <= 27'(qa * trg_pkg::COEF_L);
      p_s <= 30'(qb * trg_pkg::COEF_S);
    end
  end

  always_comb begin
    grade_w = 5'd0;
    if (s_short) cls_w = trg_pkg::CLS_PRESCHOOL;
    else if (s_nowords) cls_w = trg_pkg::CLS_NO_WORDS;
    else if (neg) cls_w = trg_pkg::CLS_PRESCHOOL;
    else if (big) cls_w = trg_pkg::CLS_ABOVE;
    else if (qa[4:0] > top_grade) cls_w = trg_pkg::CLS_ABOVE;
    else if (qa[4:0] == 5'd0) cls_w = trg_pkg::CLS_PRESCHOOL;
    else begin
      cls_w   = trg_pkg::CLS_GRADE;
      grade_w = qa[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      char_count       <= s_chars;
      letter_count     <= s_letters;
      word_count       <= s_words;
      sentence_count   <= s_sents;
      missing_end_mark <= s_missing;
      grade_class      <= cls_w;
      grade            <= grade_w;
    end
  end

endmodule

// ===== rtl/text_readability_grader.sv =====
// Timing: an item that is not the last of its text is counted in the cycle it is
// accepted. A last item yields its result after a 19-step restoring divider, a
// multiply, a rounding step and a reciprocal scaling by the unit, all of which are
// skipped when the text is short or has no words.
// Throughput: one item per cycle while a text streams in; after a last item, input
// is held off until its result is in the output register.
// Reset (rst, synchronous): counts clear, min_text_length = 50, top_grade = 16.
module text_readability_grader #(
  parameter int MAX_TEXT = 2048
) (
  input  logic        clk,
  input  logic        rst,
  trg_in_if.sink      text_in,
  trg_out_if.source   grade_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [11:0]   min_len;
  logic [4:0]    top_grade;
  trg_pkg::cmd_t cmd;
  trg_pkg::sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len   <= trg_pkg::RST_MIN_LEN;
      top_grade <= trg_pkg::RST_TOP;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == trg_pkg::REG_MIN_LEN) min_len <= pwdata[11:0];
      else top_grade <= pwdata[4:0];
    end
  end

  always_comb begin
    if (paddr[2] == trg_pkg::REG_TOP) prdata = {27'b0, top_grade};
    else prdata = {20'b0, min_len};
  end

  trg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (text_in.valid),
    .in_last   (text_in.last_char),
    .in_ready  (text_in.ready),
    .out_valid (grade_out.valid),
    .out_ready (grade_out.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  trg_dpath #(.MAX_TEXT(MAX_TEXT)) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .char_code        (text_in.char_code),
    .last_char        (text_in.last_char),
    .min_len          (min_len),
    .top_grade        (top_grade),
    .char_count       (grade_out.char_count),
    .letter_count     (grade_out.letter_count),
    .word_count       (grade_out.word_count),
    .sentence_count   (grade_out.sentence_count),
    .missing_end_mark (grade_out.missing_end_mark),
    .grade_class      (grade_out.grade_class),
    .grade            (grade_out.grade)
  );

endmodule
